### design/psdd_pkg.sv
package psdd_pkg;

  localparam int ERROR_BITS  = 16;
  localparam int SUM_W       = 10;
  localparam int KP_W        = 13;
  localparam int KI_W        = 10;
  localparam int KD_W        = 10;
  localparam int CORR_W      = 11;
  localparam int DRIVE_W     = 12;
  localparam int FACTOR_W    = 9;
  localparam int VEL_W       = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 13;

  localparam int INTEG_LIMIT = 256;

  // product and sum widths follow the error width
  localparam int DIFF_W = ERROR_BITS + 1;
  localparam int P_W    = ERROR_BITS + KP_W + 1;
  localparam int I_W    = SUM_W + KI_W + 1;
  localparam int D_W    = DIFF_W + KD_W + 1;
  localparam int N_W    = P_W + 2;

  // rounding: q = (|n| + 12800) / 25600 = ((|n| + 12800) >> 8) / 100
  localparam int HALF_DIV   = 12800;
  localparam int PRE_SHIFT  = 8;
  localparam int DIVISOR    = 100;
  localparam int Q_W        = CORR_W;
  // magnitude above this cannot change the clamped result
  localparam int T_MAX      = ((1 << Q_W) - 1) * DIVISOR + DIVISOR - 1;
  localparam int T_W        = $clog2(T_MAX + 1);
  localparam int RECIP_SHIFT = T_W + 6;
  localparam int RECIP      = (1 << RECIP_SHIFT) / DIVISOR;
  localparam int RECIP_W    = $clog2(RECIP + 1);
  localparam int PROD_W     = T_W + RECIP_W;

  localparam int VS_W = VEL_W + FACTOR_W;
  localparam int X_W  = VS_W + 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KP         = 3'd0,
    CFG_KI         = 3'd1,
    CFG_KD         = 3'd2,
    CFG_CORR_LOW   = 3'd3,
    CFG_CORR_HIGH  = 3'd4
  } cfg_reg_t;

  localparam logic signed [CORR_W-1:0] CORR_LOW_RST  = -11'sd100;
  localparam logic signed [CORR_W-1:0] CORR_HIGH_RST = 11'sd100;

  typedef struct packed {
    logic load_a;
    logic load_b;
    logic valid_a;
  } div_ctl_t;

endpackage

### design/psdd_in_if.sv
interface psdd_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [psdd_pkg::ERROR_BITS-1:0] steer_error;
  logic [psdd_pkg::FACTOR_W-1:0]          speed_factor;
  logic [psdd_pkg::VEL_W-1:0]             base_velocity;
  logic                                   restart;

  modport source (output valid, steer_error, speed_factor, base_velocity, restart,
                  input ready);
  modport sink (input valid, steer_error, speed_factor, base_velocity, restart,
                output ready);
endinterface

### design/psdd_out_if.sv
interface psdd_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [psdd_pkg::CORR_W-1:0]  correction;
  logic signed [psdd_pkg::DRIVE_W-1:0] left_drive;
  logic signed [psdd_pkg::DRIVE_W-1:0] right_drive;

  modport source (output valid, correction, left_drive, right_drive, input ready);
  modport sink (input valid, correction, left_drive, right_drive, output ready);
endinterface

### design/psdd_div100.sv
module psdd_div100 (
  input  logic                       clk,
  input  logic                       rst_n,
  input  psdd_pkg::div_ctl_t         ctl,
  input  logic [psdd_pkg::T_W-1:0]   t_in,
  input  logic                       neg_in,
  output logic [psdd_pkg::Q_W-1:0]   q_out,
  output logic                       neg_out
);

  logic [psdd_pkg::T_W-1:0]    t_r;
  logic                        neg_a_r;
  logic [psdd_pkg::PROD_W-1:0] prod_r;
  logic [psdd_pkg::PROD_W-1:0] prod_nxt;
  logic [psdd_pkg::Q_W-1:0]    q_est;
  logic [psdd_pkg::T_W-1:0]    rem;
  logic [psdd_pkg::Q_W-1:0]    q_nxt;
  logic [psdd_pkg::Q_W-1:0]    q_r;
  logic                        neg_b_r;

  assign prod_nxt = psdd_pkg::PROD_W'(t_in) * psdd_pkg::PROD_W'(psdd_pkg::RECIP);

  // reciprocal estimate is exact or one low
  assign q_est = prod_r[psdd_pkg::RECIP_SHIFT +: psdd_pkg::Q_W];
  assign rem   = t_r - psdd_pkg::T_W'(psdd_pkg::T_W'(q_est) *
                                      psdd_pkg::T_W'(psdd_pkg::DIVISOR));
  assign q_nxt = q_est + psdd_pkg::Q_W'(rem >= psdd_pkg::T_W'(psdd_pkg::DIVISOR));

  always_ff @(posedge clk) begin
    if (ctl.load_a) begin
      t_r     <= t_in;
      neg_a_r <= neg_in;
      prod_r  <= prod_nxt;
    end
    if (ctl.load_b) begin
      q_r     <= q_nxt;
      neg_b_r <= neg_a_r;
    end
  end

  assign q_out   = q_r;
  assign neg_out = neg_b_r;

`ifndef NO_ASSERTIONS
  a_est_within_one: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.valid_a |-> rem < psdd_pkg::T_W'(2 * psdd_pkg::DIVISOR))
    else $error("quotient estimate off by more than one");
`endif

endmodule

### design/pid_steering_differential_drive.sv
// PID steering correction for a differential drive.
// in_chan carries one request per control sample: steer_error (signed Q8.8),
// speed_factor (Q1.8, 256 = 1.0), base_velocity and restart. restart clears
// the integral and the previous error before that sample is used.
// out_chan returns one result per request, in order: the clamped correction
// and the left and right wheel drives.
// Gains and the correction clamps are written through cfg_we/cfg_index/
// cfg_wdata while no request is in flight.
// out_chan.valid rises when an accepted request reaches the output register;
// one request is accepted every cycle unless a full pipeline is stalled. The integral
// and previous error update at accept, so samples can follow back to back;
// the rest is an 8 stage pipeline (operands, four products, sum, rounding,
// a two stage reciprocal divide by 100, clamp, drive adds).
// Each stage holds while the one after it is full and stalled, so a stalled
// receiver fills the pipeline before in_chan.ready drops.
// Reset (rst_n low, synchronous) empties the pipeline, zeroes the gains and
// the controller history and sets the clamps to -100 and 100.
module pid_steering_differential_drive (
  input  logic                                  clk,
  input  logic                                  rst_n,
  psdd_in_if.sink                               in_chan,
  psdd_out_if.source                            out_chan,
  input  logic                                  cfg_we,
  input  logic [psdd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [psdd_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  // configuration
  logic [psdd_pkg::KP_W-1:0]          kp_r;
  logic [psdd_pkg::KI_W-1:0]          ki_r;
  logic [psdd_pkg::KD_W-1:0]          kd_r;
  logic signed [psdd_pkg::CORR_W-1:0] corr_low_r;
  logic signed [psdd_pkg::CORR_W-1:0] corr_high_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r        <= '0;
      ki_r        <= '0;
      kd_r        <= '0;
      corr_low_r  <= psdd_pkg::CORR_LOW_RST;
      corr_high_r <= psdd_pkg::CORR_HIGH_RST;
    end else if (cfg_we) begin
      case (psdd_pkg::cfg_reg_t'(cfg_index))
        psdd_pkg::CFG_KP:        kp_r        <= cfg_wdata[psdd_pkg::KP_W-1:0];
        psdd_pkg::CFG_KI:        ki_r        <= cfg_wdata[psdd_pkg::KI_W-1:0];
        psdd_pkg::CFG_KD:        kd_r        <= cfg_wdata[psdd_pkg::KD_W-1:0];
        psdd_pkg::CFG_CORR_LOW:  corr_low_r  <= cfg_wdata[psdd_pkg::CORR_W-1:0];
        psdd_pkg::CFG_CORR_HIGH: corr_high_r <= cfg_wdata[psdd_pkg::CORR_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, vo_r;
  logic en1, en2, en3, en4, en5, en6, en7, en_o;
  logic accept;

  assign en_o = !vo_r || out_chan.ready;
  assign en7  = !v7_r || en_o;
  assign en6  = !v6_r || en7;
  assign en5  = !v5_r || en6;
  assign en4  = !v4_r || en5;
  assign en3  = !v3_r || en4;
  assign en2  = !v2_r || en3;
  assign en1  = !v1_r || en2;

  assign in_chan.ready = en1;
  assign accept        = in_chan.valid && en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (en1)  v1_r <= in_chan.valid;
      if (en2)  v2_r <= v1_r;
      if (en3)  v3_r <= v2_r;
      if (en4)  v4_r <= v3_r;
      if (en5)  v5_r <= v4_r;
      if (en6)  v6_r <= v5_r;
      if (en7)  v7_r <= v6_r;
      if (en_o) vo_r <= v7_r;
    end
  end

  // controller history, updated at accept
  logic signed [psdd_pkg::SUM_W-1:0]      error_sum_r;
  logic signed [psdd_pkg::ERROR_BITS-1:0] last_error_r;
  logic signed [psdd_pkg::SUM_W-1:0]      sum_base;
  logic signed [psdd_pkg::ERROR_BITS-1:0] last_base;
  logic signed [psdd_pkg::DIFF_W-1:0]     sum_ext;
  logic signed [psdd_pkg::SUM_W-1:0]      sum_nxt;
  logic signed [psdd_pkg::DIFF_W-1:0]     diff_nxt;

  assign sum_base  = in_chan.restart ? '0 : error_sum_r;
  assign last_base = in_chan.restart ? '0 : last_error_r;
  assign sum_ext   = psdd_pkg::DIFF_W'(in_chan.steer_error) + psdd_pkg::DIFF_W'(sum_base);
  assign diff_nxt  = psdd_pkg::DIFF_W'(in_chan.steer_error) - psdd_pkg::DIFF_W'(last_base);

  always_comb begin
    if (sum_ext > psdd_pkg::DIFF_W'(psdd_pkg::INTEG_LIMIT)) begin
      sum_nxt = psdd_pkg::SUM_W'(psdd_pkg::INTEG_LIMIT);
    end else if (sum_ext < -psdd_pkg::DIFF_W'(psdd_pkg::INTEG_LIMIT)) begin
      sum_nxt = -psdd_pkg::SUM_W'(psdd_pkg::INTEG_LIMIT);
    end else begin
      sum_nxt = sum_ext[psdd_pkg::SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      error_sum_r  <= '0;
      last_error_r <= '0;
    end else if (accept) begin
      error_sum_r  <= sum_nxt;
      last_error_r <= in_chan.steer_error;
    end
  end

  // stage 1: operands
  logic signed [psdd_pkg::ERROR_BITS-1:0] e1_r;
  logic signed [psdd_pkg::SUM_W-1:0]      sum1_r;
  logic signed [psdd_pkg::DIFF_W-1:0]     diff1_r;
  logic [psdd_pkg::VEL_W-1:0]             vel1_r;
  logic [psdd_pkg::FACTOR_W-1:0]          fac1_r;

  always_ff @(posedge clk) begin
    if (en1) begin
      e1_r    <= in_chan.steer_error;
      sum1_r  <= sum_nxt;
      diff1_r <= diff_nxt;
      vel1_r  <= in_chan.base_velocity;
      fac1_r  <= in_chan.speed_factor;
    end
  end

  // stage 2: products
  logic signed [psdd_pkg::P_W-1:0] p2_r;
  logic signed [psdd_pkg::I_W-1:0] i2_r;
  logic signed [psdd_pkg::D_W-1:0] d2_r;
  logic [psdd_pkg::VS_W-1:0]       vs2_r;

  always_ff @(posedge clk) begin
    if (en2) begin
      p2_r  <= psdd_pkg::P_W'(e1_r) * psdd_pkg::P_W'($signed({1'b0, kp_r}));
      i2_r  <= psdd_pkg::I_W'(sum1_r) * psdd_pkg::I_W'($signed({1'b0, ki_r}));
      d2_r  <= psdd_pkg::D_W'(diff1_r) * psdd_pkg::D_W'($signed({1'b0, kd_r}));
      vs2_r <= psdd_pkg::VS_W'(vel1_r) * psdd_pkg::VS_W'(fac1_r);
    end
  end

  // stage 3: pid sum
  logic signed [psdd_pkg::N_W-1:0] n3_r;
  logic [psdd_pkg::VS_W-1:0]       vs3_r;

  always_ff @(posedge clk) begin
    if (en3) begin
      n3_r  <= psdd_pkg::N_W'(p2_r) + psdd_pkg::N_W'(i2_r) + psdd_pkg::N_W'(d2_r);
      vs3_r <= vs2_r;
    end
  end

  // stage 4: magnitude, half add, pre-shift and saturate
  logic [psdd_pkg::N_W-1:0] mag3;
  logic [psdd_pkg::N_W-1:0] t_full;
  logic [psdd_pkg::T_W-1:0] t_nxt;
  logic [psdd_pkg::T_W-1:0] t4_r;
  logic                     neg4_r;
  logic [psdd_pkg::VS_W-1:0] vs4_r;

  assign mag3   = n3_r[psdd_pkg::N_W-1] ? psdd_pkg::N_W'(-n3_r) : psdd_pkg::N_W'(n3_r);
  assign t_full = (mag3 + psdd_pkg::N_W'(psdd_pkg::HALF_DIV)) >> psdd_pkg::PRE_SHIFT;
  assign t_nxt  = (t_full > psdd_pkg::N_W'(psdd_pkg::T_MAX)) ?
                  psdd_pkg::T_W'(psdd_pkg::T_MAX) : t_full[psdd_pkg::T_W-1:0];

  always_ff @(posedge clk) begin
    if (en4) begin
      t4_r   <= t_nxt;
      neg4_r <= n3_r[psdd_pkg::N_W-1];
      vs4_r  <= vs3_r;
    end
  end

  // stages 5 and 6: divide by 100
  psdd_pkg::div_ctl_t        div_ctl;
  logic [psdd_pkg::Q_W-1:0]  q6;
  logic                      neg6;
  logic [psdd_pkg::VS_W-1:0] vs5_r;
  logic [psdd_pkg::VS_W-1:0] vs6_r;

  assign div_ctl.load_a  = en5;
  assign div_ctl.load_b  = en6;
  assign div_ctl.valid_a = v5_r;

  psdd_div100 u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (div_ctl),
    .t_in    (t4_r),
    .neg_in  (neg4_r),
    .q_out   (q6),
    .neg_out (neg6)
  );

  always_ff @(posedge clk) begin
    if (en5) vs5_r <= vs4_r;
    if (en6) vs6_r <= vs5_r;
  end

  // stage 7: sign and clamp
  logic signed [psdd_pkg::Q_W:0]      c_signed;
  logic signed [psdd_pkg::Q_W:0]      low_ext;
  logic signed [psdd_pkg::Q_W:0]      high_ext;
  logic signed [psdd_pkg::CORR_W-1:0] c_nxt;
  logic signed [psdd_pkg::CORR_W-1:0] c7_r;
  logic [psdd_pkg::VS_W-1:0]          vs7_r;

  assign c_signed = neg6 ? -$signed({1'b0, q6}) : $signed({1'b0, q6});
  assign low_ext  = (psdd_pkg::Q_W+1)'(corr_low_r);
  assign high_ext = (psdd_pkg::Q_W+1)'(corr_high_r);

  // when the clamp registers are inverted, values above high take high and all others take low
  always_comb begin
    if (c_signed > high_ext) begin
      c_nxt = corr_high_r;
    end else if (c_signed < low_ext) begin
      c_nxt = corr_low_r;
    end else begin
      c_nxt = c_signed[psdd_pkg::CORR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en7) begin
      c7_r  <= c_nxt;
      vs7_r <= vs6_r;
    end
  end

  // output stage: drives truncated toward zero
  logic signed [psdd_pkg::X_W-1:0]     vs_ext;
  logic signed [psdd_pkg::X_W-1:0]     c_scaled;
  logic signed [psdd_pkg::X_W-1:0]     left_x;
  logic signed [psdd_pkg::X_W-1:0]     right_x;
  logic signed [psdd_pkg::X_W-1:0]     left_b;
  logic signed [psdd_pkg::X_W-1:0]     right_b;
  logic signed [psdd_pkg::CORR_W-1:0]  out_corr_r;
  logic signed [psdd_pkg::DRIVE_W-1:0] out_left_r;
  logic signed [psdd_pkg::DRIVE_W-1:0] out_right_r;

  assign vs_ext   = $signed({{(psdd_pkg::X_W-psdd_pkg::VS_W){1'b0}}, vs7_r});
  assign c_scaled = psdd_pkg::X_W'(c7_r) <<< psdd_pkg::PRE_SHIFT;
  assign left_x   = vs_ext + c_scaled;
  assign right_x  = vs_ext - c_scaled;
  assign left_b   = left_x + (left_x[psdd_pkg::X_W-1] ? psdd_pkg::X_W'(255) : '0);
  assign right_b  = right_x + (right_x[psdd_pkg::X_W-1] ? psdd_pkg::X_W'(255) : '0);

  always_ff @(posedge clk) begin
    if (en_o) begin
      out_corr_r  <= c7_r;
      out_left_r  <= left_b[psdd_pkg::PRE_SHIFT +: psdd_pkg::DRIVE_W];
      out_right_r <= right_b[psdd_pkg::PRE_SHIFT +: psdd_pkg::DRIVE_W];
    end
  end

  assign out_chan.valid       = vo_r;
  assign out_chan.correction  = out_corr_r;
  assign out_chan.left_drive  = out_left_r;
  assign out_chan.right_drive = out_right_r;

`ifndef NO_ASSERTIONS
  a_integral_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    error_sum_r <= psdd_pkg::SUM_W'(psdd_pkg::INTEG_LIMIT) &&
    error_sum_r >= -psdd_pkg::SUM_W'(psdd_pkg::INTEG_LIMIT))
    else $error("integral outside its clamp");

  a_last_error_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> last_error_r == $past(in_chan.steer_error))
    else $error("previous error not taken from accepted request");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> (vo_r && !out_chan.ready && v1_r && v4_r && v7_r))
    else $error("input stalled with room in the pipeline");
`endif

endmodule
